// ----- hw/rtl/bpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpfa_pkg: shared types and constants for the bitmap page-frame allocator
// Holds the beat payload structs, opcodes, register indexes and sequencer
// states used by the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

    // Default geometry
    localparam int NUM_BLOCKS_DEF  = 32768;
    localparam int BLOCK_BYTES_DEF = 4096;
    localparam int WORD_BITS       = 32;

    // Configuration register file
    localparam int                  TOTAL_BLOCKS_W   = 16;
    localparam logic [15:0]         TOTAL_BLOCKS_RST = 16'd32768;
    localparam int                  PADDR_W          = 3;
    localparam logic                IDX_TOTAL_BLOCKS = 1'b0;

    // Opcodes
    localparam logic [2:0] OP_MARK_ALL       = 3'd0;
    localparam logic [2:0] OP_FREE_REGION    = 3'd1;
    localparam logic [2:0] OP_RESERVE_REGION = 3'd2;
    localparam logic [2:0] OP_ALLOC          = 3'd3;
    localparam logic [2:0] OP_FREE           = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] address;
        logic [31:0] size;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] block_address;
        logic [15:0] free_blocks;
        logic [15:0] used_now;
    } result_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_PREP,
        ST_PREP2,
        ST_RG_RD,
        ST_RG_WR,
        ST_B0_RD,
        ST_B0_WR,
        ST_ALLOC,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bitmap_page_frame_allocator_unit.sv -----
// Sequencing: mark_all sweeps every bitmap word; free_region and reserve_region read
//   and write back each touched bitmap word (plus the block 0 fixup of free_region);
//   alloc reads up to mg/32 words (one word read per cycle); free touches one word.
// Throughput: one item at a time; the bitmap RAM and its one word
//   read-modify-write unit set the pace. The result register frees the output side.
// Reset: a sweep writes all ones into the bitmap, stall high.
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_unit: bitmap page-frame allocator
// One bit per block in a word-wide RAM (1 = used), a saturating used-block
// counter, and a small sequencer that walks the RAM one word at a time.
// BLOCK_BYTES must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_frame_allocator_unit #(
    parameter int NUM_BLOCKS  = bpfa_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = bpfa_pkg::BLOCK_BYTES_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,

    // item channel
    input  wire                           item_valid,
    output logic                          item_stall,
    input  wire bpfa_pkg::item_t          item,

    // result channel
    output logic                          result_valid,
    input  wire                           result_stall,
    output bpfa_pkg::result_t             result,

    // APB-style configuration port
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [bpfa_pkg::PADDR_W-1:0]   paddr,
    input  wire [31:0]                    pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------------
    // Derived geometry
    // ------------------------------------------------------------------------
    localparam int MAP_WORDS = (NUM_BLOCKS + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
    localparam int AW        = $clog2(MAP_WORDS);           // bitmap word address
    localparam int BLK_W     = AW + 5;                      // block index inside the map
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
    localparam int UW        = (CNT_W > 16) ? CNT_W : 16;   // used counter width
    localparam int SCAN_W    = AW + 1;                      // scan pointer, holds MAP_WORDS
    localparam int CMP_W     = (SCAN_W > 11) ? SCAN_W : 11;
    localparam int BB_SH     = $clog2(BLOCK_BYTES);
    localparam int BLKA_W    = 32 - BB_SH;                  // block index of a byte address

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    bpfa_pkg::state_t   state_reg, state_next;
    logic [AW-1:0]      sweep_reg, sweep_next;
    logic               sweep_op_reg, sweep_op_next;    // sweep serves mark_all, not reset
    logic [UW-1:0]      used_reg, used_next;
    logic [15:0]        total_reg, total_next;
    logic [SCAN_W-1:0]  scan_reg, scan_next;
    logic               pend_reg, pend_next;            // a scan read is in flight
    logic               result_valid_reg, result_valid_next;
    logic               set_reg, set_next;              // region sets bits (else clears)
    logic               bit0_reg, bit0_next;            // set block 0 after the walk

    bpfa_pkg::item_t    item_reg, item_next;
    logic [BLK_W:0]     first_reg, first_next;
    logic [BLK_W:0]     end_reg, end_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic [AW-1:0]      last_reg, last_next;
    logic [4:0]         endoff_reg, endoff_next;
    logic [AW-1:0]      pend_word_reg, pend_word_next;
    logic               ok_reg, ok_next;
    logic [31:0]        addr_reg, addr_next;
    bpfa_pkg::result_t  result_reg, result_next;
    logic [31:0]        rdata_reg;

    // Bitmap RAM: one write port, one registered read port
    logic [31:0]        map_mem [MAP_WORDS];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;
    logic [AW-1:0]      mem_raddr;

    // ------------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------------
    logic [15:0]        mg;                 // managed block count
    logic [10:0]        words;              // whole words alloc may scan
    logic               cfg_wr;

    logic [32:0]        first_full;
    logic [32:0]        n_raw;
    logic [32:0]        n_full;
    logic [33:0]        end_full;
    logic [BLKA_W-1:0]  blk_full;
    logic [BLK_W:0]     end_m1;

    logic [4:0]         lo_off;
    logic [4:0]         last_off;
    logic [31:0]        mask;
    logic [5:0]         k;
    logic [UW:0]        sum_up;

    logic               issue;
    logic [31:0]        zeros;
    logic [4:0]         hit_off;
    logic [BLK_W-1:0]   hit_blk;

    assign mg     = (32'(total_reg) < 32'(NUM_BLOCKS)) ? total_reg : 16'(NUM_BLOCKS);
    assign words  = mg[15:5];
    assign cfg_wr = psel && penable && pwrite && pready;

    // Region rounding: start and length round up to whole blocks, without wrap
    assign first_full = ({1'b0, item_reg.address} + 33'(BLOCK_BYTES - 1)) >> BB_SH;
    assign n_raw      = ({1'b0, item_reg.size} + 33'(BLOCK_BYTES - 1)) >> BB_SH;
    assign n_full     = (n_raw == 33'd0) ? 33'd1 : n_raw;
    assign end_full   = {1'b0, first_full} + {1'b0, n_full};
    assign blk_full   = item_reg.address[31:BB_SH];
    assign end_m1     = end_reg - (BLK_W+1)'(1);

    // Word mask of the blocks that the walk touches in the current word
    assign lo_off   = (cur_reg == first_reg[BLK_W-1:5]) ? first_reg[4:0] : 5'd0;
    assign last_off = (cur_reg == last_reg) ? endoff_reg : 5'd31;
    assign mask     = (32'hFFFF_FFFF << lo_off) & (32'hFFFF_FFFF >> (5'd31 - last_off));
    assign k        = {1'b0, last_off} - {1'b0, lo_off} + 6'd1;
    assign sum_up   = {1'b0, used_reg} + (UW+1)'(k);

    // Alloc scan: lowest clear bit of the word that came back
    assign issue = CMP_W'(scan_reg) < CMP_W'(words);
    assign zeros = ~rdata_reg;

    always_comb
    begin
        hit_off = 5'd0;
        for (int o = 31; o >= 0; o--)
        begin
            if (zeros[o])
            begin
                hit_off = 5'(o);
            end
        end
    end

    assign hit_blk = {pend_word_reg, hit_off};

    // ------------------------------------------------------------------------
    // Sequencer: next state, datapath and RAM controls
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        sweep_next        = sweep_reg;
        sweep_op_next     = sweep_op_reg;
        used_next         = used_reg;
        total_next        = total_reg;
        scan_next         = scan_reg;
        pend_next         = pend_reg;
        result_valid_next = result_valid_reg;
        set_next          = set_reg;
        bit0_next         = bit0_reg;
        item_next         = item_reg;
        first_next        = first_reg;
        end_next          = end_reg;
        cur_next          = cur_reg;
        last_next         = last_reg;
        endoff_next       = endoff_reg;
        pend_word_next    = pend_word_reg;
        ok_next           = ok_reg;
        addr_next         = addr_reg;
        result_next       = result_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '1;
        mem_raddr = '0;

        // drop the result beat once it is taken
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (cfg_wr && paddr[2] == bpfa_pkg::IDX_TOTAL_BLOCKS)
        begin
            total_next = pwdata[15:0];
        end

        case (state_reg)
            bpfa_pkg::ST_SWEEP:
            begin
                // fill one word with ones per cycle
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = '1;
                if (sweep_reg == AW'(MAP_WORDS - 1))
                begin
                    state_next = sweep_op_reg ? bpfa_pkg::ST_FINISH : bpfa_pkg::ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end

            bpfa_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = bpfa_pkg::ST_PREP;
                end
            end

            bpfa_pkg::ST_PREP:
            begin
                addr_next = 32'd0;
                ok_next   = 1'b1;
                case (item_reg.opcode)
                    bpfa_pkg::OP_MARK_ALL:
                    begin
                        used_next     = UW'(mg);
                        sweep_next    = '0;
                        sweep_op_next = 1'b1;
                        state_next    = bpfa_pkg::ST_SWEEP;
                    end
                    bpfa_pkg::OP_FREE_REGION,
                    bpfa_pkg::OP_RESERVE_REGION:
                    begin
                        set_next  = (item_reg.opcode == bpfa_pkg::OP_RESERVE_REGION);
                        bit0_next = (item_reg.opcode == bpfa_pkg::OP_FREE_REGION);
                        first_next = first_full[BLK_W:0];
                        end_next   = (end_full > 34'(NUM_BLOCKS)) ? (BLK_W+1)'(NUM_BLOCKS)
                                                                  : end_full[BLK_W:0];
                        if (first_full >= 33'(NUM_BLOCKS))
                        begin
                            // region lies wholly past the map
                            state_next = (item_reg.opcode == bpfa_pkg::OP_FREE_REGION)
                                       ? bpfa_pkg::ST_B0_RD : bpfa_pkg::ST_FINISH;
                        end
                        else
                        begin
                            state_next = bpfa_pkg::ST_PREP2;
                        end
                    end
                    bpfa_pkg::OP_ALLOC:
                    begin
                        ok_next   = 1'b0;
                        scan_next = '0;
                        pend_next = 1'b0;
                        state_next = (used_reg < UW'(mg)) ? bpfa_pkg::ST_ALLOC
                                                          : bpfa_pkg::ST_FINISH;
                    end
                    bpfa_pkg::OP_FREE:
                    begin
                        set_next   = 1'b0;
                        bit0_next  = 1'b0;
                        first_next = (BLK_W+1)'(blk_full);
                        end_next   = (BLK_W+1)'(blk_full) + (BLK_W+1)'(1);
                        state_next = (32'(blk_full) < 32'(NUM_BLOCKS)) ? bpfa_pkg::ST_PREP2
                                                                       : bpfa_pkg::ST_FINISH;
                    end
                    default:
                    begin
                        ok_next    = 1'b0;
                        state_next = bpfa_pkg::ST_FINISH;
                    end
                endcase
            end

            bpfa_pkg::ST_PREP2:
            begin
                cur_next    = first_reg[BLK_W-1:5];
                last_next   = end_m1[BLK_W-1:5];
                endoff_next = end_m1[4:0];
                state_next  = bpfa_pkg::ST_RG_RD;
            end

            bpfa_pkg::ST_RG_RD:
            begin
                mem_raddr  = cur_reg;
                state_next = bpfa_pkg::ST_RG_WR;
            end

            bpfa_pkg::ST_RG_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                mem_wdata = set_reg ? (rdata_reg | mask) : (rdata_reg & ~mask);
                // saturate at managed going up, at zero going down
                if (set_reg)
                begin
                    if (used_reg < UW'(mg))
                    begin
                        used_next = (sum_up > (UW+1)'(mg)) ? UW'(mg) : sum_up[UW-1:0];
                    end
                end
                else
                begin
                    used_next = (used_reg >= UW'(k)) ? (used_reg - UW'(k)) : '0;
                end
                if (cur_reg == last_reg)
                begin
                    state_next = bit0_reg ? bpfa_pkg::ST_B0_RD : bpfa_pkg::ST_FINISH;
                end
                else
                begin
                    cur_next   = cur_reg + AW'(1);
                    state_next = bpfa_pkg::ST_RG_RD;
                end
            end

            bpfa_pkg::ST_B0_RD:
            begin
                mem_raddr  = '0;
                state_next = bpfa_pkg::ST_B0_WR;
            end

            bpfa_pkg::ST_B0_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = rdata_reg | 32'd1;
                state_next = bpfa_pkg::ST_FINISH;
            end

            bpfa_pkg::ST_ALLOC:
            begin
                if (pend_reg && rdata_reg != '1)
                begin
                    // hit on block 0 counts as a failure
                    if (hit_blk != '0)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pend_word_reg;
                        mem_wdata = rdata_reg | (32'd1 << hit_off);
                        used_next = used_reg + UW'(1);
                        ok_next   = 1'b1;
                        addr_next = 32'(64'(hit_blk) << BB_SH);
                    end
                    state_next = bpfa_pkg::ST_FINISH;
                end
                else if (!issue && !pend_reg)
                begin
                    state_next = bpfa_pkg::ST_FINISH;
                end
                else
                begin
                    mem_raddr      = scan_reg[AW-1:0];
                    pend_next      = issue;
                    pend_word_next = scan_reg[AW-1:0];
                    scan_next      = scan_reg + SCAN_W'(issue);
                end
            end

            bpfa_pkg::ST_FINISH:
            begin
                // hold until the result register is free or being emptied
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.ok            = ok_reg;
                    result_next.block_address = addr_reg;
                    result_next.free_blocks   = (used_reg >= UW'(mg)) ? 16'd0
                                                : 16'(UW'(mg) - used_reg);
                    result_next.used_now      = used_reg[15:0];
                    result_valid_next         = 1'b1;
                    state_next                = bpfa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bpfa_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control state (reset)
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bpfa_pkg::ST_SWEEP;
            sweep_reg        <= '0;
            sweep_op_reg     <= 1'b0;
            used_reg         <= UW'(NUM_BLOCKS);
            total_reg        <= bpfa_pkg::TOTAL_BLOCKS_RST;
            scan_reg         <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            set_reg          <= 1'b0;
            bit0_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            sweep_op_reg     <= sweep_op_next;
            used_reg         <= used_next;
            total_reg        <= total_next;
            scan_reg         <= scan_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
            set_reg          <= set_next;
            bit0_reg         <= bit0_next;
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        first_reg     <= first_next;
        end_reg       <= end_next;
        cur_reg       <= cur_next;
        last_reg      <= last_next;
        endoff_reg    <= endoff_next;
        pend_word_reg <= pend_word_next;
        ok_reg        <= ok_next;
        addr_reg      <= addr_next;
        result_reg    <= result_next;
    end

    // ------------------------------------------------------------------------
    // Bitmap RAM
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= map_mem[mem_raddr];
    end

    // ------------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------------
    assign item_stall   = (state_reg != bpfa_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == bpfa_pkg::IDX_TOTAL_BLOCKS) ? {16'd0, total_reg}
                                                                   : 32'd0;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(NUM_BLOCKS))
        else $error("used count above map size");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.ok || result.block_address == 32'd0))
        else $error("failed beat carries an address");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpfa_pkg::ST_RG_RD || state_reg == bpfa_pkg::ST_RG_WR)
            |-> cur_reg <= last_reg)
        else $error("region walk ran past its last word");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for bitmap_page_frame_allocator_unit
// Drives opcode beats through the valid/stall item channel, tracks the block
// map and used-block count in a scoreboard of its own, and checks every result
// beat field by field. total_blocks is reprogrammed over the APB-style port
// between phases, and the phases cycle through four mixes of sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int MAP_WORDS      = bpfa_pkg::NUM_BLOCKS_DEF / bpfa_pkg::WORD_BITS;
    localparam int PHASES         = 8;
    localparam int BEATS_PER_PHASE = 165;
    // Slowest opcode reads and writes back every word of the map.
    // Give every beat that worst case plus long gaps and stalls, with a wide margin.
    localparam int CYCLE_LIMIT    = 20_000_000;
    localparam int DRAIN_CYCLES   = 2 * MAP_WORDS + 16;
    localparam int SHOWN_MISMATCHES = 10;

    // Opcodes the block does not define; it must answer them with ok low.
    localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

    localparam logic [bpfa_pkg::PADDR_W-1:0] TOTAL_BLOCKS_ADDR =
        bpfa_pkg::PADDR_W'(4 * int'(bpfa_pkg::IDX_TOTAL_BLOCKS));

    // ------------------------------------------------------------------------
    // Scoreboard: private copy of the block map, used-block count and
    // total_blocks, plus the queue of result beats still owed by the block.
    // ------------------------------------------------------------------------
    class alloc_scoreboard;
        bit [bpfa_pkg::WORD_BITS-1:0]      map_words [MAP_WORDS];
        int unsigned                       used_tally;
        bit [bpfa_pkg::TOTAL_BLOCKS_W-1:0] total_blocks;
        bpfa_pkg::result_t                 owed_results[$];
        int unsigned                       mismatches;
        int unsigned                       results_checked;
        int unsigned                       beats_taken;
        int unsigned                       allocs_granted;
        int unsigned                       allocs_refused;

        function new();
            foreach (map_words[w])
                map_words[w] = '1;
            used_tally   = bpfa_pkg::NUM_BLOCKS_DEF;
            total_blocks = bpfa_pkg::TOTAL_BLOCKS_RST;
        endfunction

        function int unsigned managed();
            return (total_blocks < bpfa_pkg::NUM_BLOCKS_DEF) ? total_blocks
                                                             : bpfa_pkg::NUM_BLOCKS_DEF;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("MISMATCH: %s", msg);
        endfunction

        // Blocks past the map are dropped silently.
        function void put_bit(longint unsigned blk, bit val);
            if (blk >= bpfa_pkg::NUM_BLOCKS_DEF)
                return;
            map_words[blk / bpfa_pkg::WORD_BITS][blk % bpfa_pkg::WORD_BITS] = val;
        endfunction

        // Increment never lifts the count past managed, nor raises a count
        // that already sits above it.
        function void bump_up();
            if (used_tally < managed())
                used_tally++;
        endfunction

        function void drop_count();
            if (used_tally > 0)
                used_tally--;
        endfunction

        // Round start and length up to whole blocks (at least one) without
        // 32-bit wrap; the count moves once per in-map block, whatever the
        // bit held before.
        function void walk_region(bit [31:0] start, bit [31:0] len, bit val);
            longint unsigned first, count, stop, s, l;
            s = start;
            l = len;
            first = (s + bpfa_pkg::BLOCK_BYTES_DEF - 1) / bpfa_pkg::BLOCK_BYTES_DEF;
            count = (l + bpfa_pkg::BLOCK_BYTES_DEF - 1) / bpfa_pkg::BLOCK_BYTES_DEF;
            if (count == 0)
                count = 1;
            stop = first + count;
            if (stop > bpfa_pkg::NUM_BLOCKS_DEF)
                stop = bpfa_pkg::NUM_BLOCKS_DEF;
            for (longint unsigned b = first; b < stop; b++)
            begin
                put_bit(b, val);
                if (val)
                    bump_up();
                else
                    drop_count();
            end
        endfunction

        // Lowest clear bit in the whole words below managed. Refuse when the
        // count says full, when no bit is clear, or when the hit is block 0.
        function bit grab_lowest_clear(output bit [31:0] byte_addr);
            int unsigned mg, words, hit;
            bit found;
            mg        = managed();
            words     = mg / bpfa_pkg::WORD_BITS;
            hit       = 0;
            found     = 1'b0;
            byte_addr = '0;
            if (used_tally >= mg)
                return 1'b0;
            for (int unsigned w = 0; w < words && w < MAP_WORDS && !found; w++)
            begin
                if (map_words[w] != '1)
                begin
                    for (int o = 0; o < bpfa_pkg::WORD_BITS; o++)
                    begin
                        if (!map_words[w][o])
                        begin
                            hit   = w * bpfa_pkg::WORD_BITS + o;
                            found = 1'b1;
                            break;
                        end
                    end
                end
            end
            if (!found || hit == 0)
                return 1'b0;
            put_bit(hit, 1'b1);
            bump_up();
            byte_addr = hit * bpfa_pkg::BLOCK_BYTES_DEF;
            return 1'b1;
        endfunction

        // Apply one accepted item beat and queue the result it must produce.
        function void note_item(bpfa_pkg::item_t beat);
            bpfa_pkg::result_t want;
            bit                granted;
            bit [31:0]         hit_addr;
            int unsigned       mg, fr, blk;
            want    = '0;
            want.ok = 1'b1;
            beats_taken++;
            case (beat.opcode)
                bpfa_pkg::OP_MARK_ALL:
                begin
                    foreach (map_words[w])
                        map_words[w] = '1;
                    used_tally = managed();
                end
                bpfa_pkg::OP_FREE_REGION:
                begin
                    walk_region(beat.address, beat.size, 1'b0);
                    put_bit(0, 1'b1);
                end
                bpfa_pkg::OP_RESERVE_REGION:
                    walk_region(beat.address, beat.size, 1'b1);
                bpfa_pkg::OP_ALLOC:
                begin
                    granted            = grab_lowest_clear(hit_addr);
                    want.ok            = granted;
                    want.block_address = hit_addr;
                    if (granted)
                        allocs_granted++;
                    else
                        allocs_refused++;
                end
                bpfa_pkg::OP_FREE:
                begin
                    blk = beat.address / bpfa_pkg::BLOCK_BYTES_DEF;
                    if (blk < bpfa_pkg::NUM_BLOCKS_DEF)
                    begin
                        put_bit(blk, 1'b0);
                        drop_count();
                    end
                end
                default:
                    want.ok = 1'b0;
            endcase
            mg = managed();
            fr = (used_tally >= mg) ? 0 : mg - used_tally;
            want.free_blocks = fr[15:0];
            want.used_now    = used_tally[15:0];
            owed_results.push_back(want);
        endfunction

        function void check_result(bpfa_pkg::result_t got);
            bpfa_pkg::result_t want;
            if (owed_results.size() == 0)
            begin
                flag($sformatf("result beat with nothing owed: ok=%0b addr=%h free=%0d used=%0d",
                               got.ok, got.block_address, got.free_blocks, got.used_now));
                return;
            end
            want = owed_results.pop_front();
            results_checked++;
            if (got.ok !== want.ok)
                flag($sformatf("result %0d ok: expected %0b, got %0b",
                               results_checked, want.ok, got.ok));
            if (got.block_address !== want.block_address)
                flag($sformatf("result %0d block_address: expected %h, got %h",
                               results_checked, want.block_address, got.block_address));
            if (got.free_blocks !== want.free_blocks)
                flag($sformatf("result %0d free_blocks: expected %0d, got %0d",
                               results_checked, want.free_blocks, got.free_blocks));
            if (got.used_now !== want.used_now)
                flag($sformatf("result %0d used_now: expected %0d, got %0d",
                               results_checked, want.used_now, got.used_now));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals; every block input starts at a known value.
    // ------------------------------------------------------------------------
    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          item_valid   = 1'b0;
    logic                          item_stall;
    bpfa_pkg::item_t               item         = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    bpfa_pkg::result_t             result;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [bpfa_pkg::PADDR_W-1:0]  paddr        = '0;
    logic [31:0]                   pwdata       = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    alloc_scoreboard sb = new();

    // Percent chance, per cycle, of a sender gap and of a receiver stall.
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;
    int unsigned settings_written = 0;

    bitmap_page_frame_allocator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Result side: check a beat at each edge where valid is high and stall is
    // low (pre-edge values), then roll the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, sb.owed_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic bpfa_pkg::item_t make_beat(logic [2:0] op, logic [31:0] addr,
                                                  logic [31:0] len);
        bpfa_pkg::item_t beat;
        beat.opcode  = op;
        beat.address = addr;
        beat.size    = len;
        return beat;
    endfunction

    // Random beat. Keep most addresses in the low blocks so alloc scans stay
    // short, most region lengths small, and let a few beats roam the whole
    // field range.
    function automatic bpfa_pkg::item_t make_random_item();
        bpfa_pkg::item_t beat;
        int unsigned     pick, span, blk;
        logic [31:0]     addr, len;
        pick = $urandom_range(0, 99);
        span = (sb.managed() < 512) ? sb.managed() : 512;
        blk  = $urandom_range(0, span - 1);
        if ($urandom_range(0, 9) == 0)
            blk = $urandom_range(0, bpfa_pkg::NUM_BLOCKS_DEF - 1);
        addr = blk * bpfa_pkg::BLOCK_BYTES_DEF;
        if ($urandom_range(0, 3) == 0)
            addr += $urandom_range(1, bpfa_pkg::BLOCK_BYTES_DEF - 1);
        len = ($urandom_range(0, 29) == 0) ? $urandom()
                                           : $urandom_range(0, 8 * bpfa_pkg::BLOCK_BYTES_DEF);
        if (pick < 2)
            beat = make_beat(bpfa_pkg::OP_MARK_ALL, addr, len);
        else if (pick < 16)
            beat = make_beat(bpfa_pkg::OP_FREE_REGION, addr, len);
        else if (pick < 28)
            beat = make_beat(bpfa_pkg::OP_RESERVE_REGION, addr, len);
        else if (pick < 60)
            beat = make_beat(bpfa_pkg::OP_ALLOC, addr, len);
        else if (pick < 88)
            beat = make_beat(bpfa_pkg::OP_FREE, addr, len);
        else if (pick < 91)
            beat = make_beat(3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST)),
                             $urandom(), $urandom());
        else
            beat = make_beat(3'($urandom_range(0, 7)), $urandom(), $urandom());
        return beat;
    endfunction

    // Offer one item beat, idling first at the current gap rate. Hold the
    // payload until the block takes it. Valid stays high into the next beat
    // when no gap is rolled.
    task automatic send_item(input bpfa_pkg::item_t beat);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(beat);
    endtask

    // Drop valid and wait until every owed result beat has come back.
    task automatic hold_until_empty();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed_results.size() != 0)
            @(posedge clk);
    endtask

    // Program total_blocks (setup then access), then read it back.
    task automatic write_total_blocks(input logic [15:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOTAL_BLOCKS_ADDR;
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.total_blocks = value;
        settings_written++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {16'h0000, value})
            sb.flag($sformatf("total_blocks readback: expected %0d, got %h", value, readback));
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bpfa_pkg::item_t directed[$];
        logic [15:0]     settings[PHASES];

        // Walk the special cases with the reset setting (every block managed):
        // full map, hit on block 0, rounding of start and length, the one
        // block minimum, blocks past the map, the count saturating at both
        // ends, a count below managed with no clear bit, the last block, and
        // the undefined opcodes.
        directed.push_back(make_beat(bpfa_pkg::OP_ALLOC,          32'h0000_0000, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_FREE,           32'h0000_0000, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_ALLOC,          32'h0000_0000, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_FREE_REGION,    32'h0000_0000, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_FREE_REGION,    32'h0000_0001, 32'h0000_0001));
        directed.push_back(make_beat(bpfa_pkg::OP_ALLOC,          32'h0000_0000, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_FREE_REGION,    32'h0000_2000, 32'h0000_5001));
        directed.push_back(make_beat(bpfa_pkg::OP_ALLOC,          32'h0000_0000, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_RESERVE_REGION, 32'h0000_3001, 32'h0000_1000));
        directed.push_back(make_beat(bpfa_pkg::OP_FREE,           32'hFFFF_FFFF, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_FREE_REGION,    32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(make_beat(bpfa_pkg::OP_RESERVE_REGION, 32'hFFFF_F000, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_RESERVE_REGION, 32'h0000_0000, 32'hFFFF_FFFF));
        directed.push_back(make_beat(bpfa_pkg::OP_ALLOC,          32'h0000_0000, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_FREE,           32'h0000_5000, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_FREE,           32'h0000_5000, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_ALLOC,          32'h0000_0000, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_ALLOC,          32'h0000_0000, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_FREE,           32'h07FF_FFFF, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_ALLOC,          32'h0000_0000, 32'h0000_0000));
        directed.push_back(make_beat(bpfa_pkg::OP_FREE_REGION,    32'h0000_0000, 32'hFFFF_FFFF));
        directed.push_back(make_beat(bpfa_pkg::OP_ALLOC,          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        for (int op = OP_UNDEF_FIRST; op <= OP_UNDEF_LAST; op++)
            directed.push_back(make_beat(3'(op), 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(make_beat(bpfa_pkg::OP_MARK_ALL,       32'h0000_0000, 32'h0000_0000));

        // total_blocks per random phase: both extremes, values that leave a
        // partial last word, and one drawn at random.
        settings = '{16'd32, 16'd32768, 16'd100, 16'd1000,
                     16'd64, 16'($urandom_range(32, 32768)), 16'd4097, 16'd32};

        // Hold reset, then release it once. The block marks its whole map used
        // afterwards with stall high; the first beat simply waits.
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i]);
        hold_until_empty();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // Block is idle here: every result has come back.
            write_total_blocks(settings[ph]);
            case (ph % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 57; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 57; end
                default: begin send_gap_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // Now and then let the pipe run dry before the next beat.
                if ($urandom_range(0, 39) == 0)
                    hold_until_empty();
                send_item(make_random_item());
            end
            hold_until_empty();
        end

        // Let any stray result beat show up before judging.
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.owed_results.size() != 0)
            sb.flag($sformatf("%0d result beats never arrived", sb.owed_results.size()));

        $display("Run covered %0d item beats over %0d total_blocks settings, %0d results checked",
                 sb.beats_taken, settings_written, sb.results_checked);
        $display("Allocs granted %0d, refused %0d; mismatches %0d",
                 sb.allocs_granted, sb.allocs_refused, sb.mismatches);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/bpfa_pkg.sv
hw/rtl/bitmap_page_frame_allocator_unit.sv
test/tb.sv
